@@ hdl/u8d_pkg.sv @@
// shared types and constants of the strict utf-8 decoder
package u8d_pkg;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO        = 21'h000080;
  localparam logic [20:0] MIN_THREE      = 21'h000800;
  localparam logic [20:0] MIN_FOUR       = 21'h010000;

  localparam logic [7:0] MASK_TOP2  = 8'hC0;
  localparam logic [7:0] MASK_TOP3  = 8'hE0;
  localparam logic [7:0] MASK_TOP4  = 8'hF0;
  localparam logic [7:0] MASK_TOP5  = 8'hF8;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;

  // results caused by one byte: a run of replacements, then an optional tail
  typedef struct packed {
    logic [2:0]  rep_count;
    logic        tail_valid;
    logic [20:0] tail_cp;
    logic        tail_bad;
    logic [2:0]  tail_cnt;
  } desc_t;

endpackage

@@ hdl/u8d_decode.sv @@
// input register, sequence state and per-byte decode into a result descriptor
module u8d_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      byte_value,
  input  logic            last_byte,
  input  logic            can_load,
  output logic            load,
  output u8d_pkg::desc_t  desc
);
  import u8d_pkg::*;

  logic        in_q_valid;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [1:0]  held_count;
  logic [1:0]  needed_count;
  logic [20:0] partial_value;
  logic [1:0]  held_count_next;
  logic [1:0]  needed_count_next;
  logic [20:0] partial_value_next;

  assign in_ready = !in_q_valid || can_load;
  assign load     = in_q_valid && can_load;

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      byte_q <= byte_value;
      last_q <= last_byte;
    end
  end

  // pending sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 2'd0;
      needed_count  <= 2'd0;
      partial_value <= 21'd0;
    end else if (load) begin
      held_count    <= held_count_next;
      needed_count  <= needed_count_next;
      partial_value <= partial_value_next;
    end
  end

  // decode of the registered byte against the pending sequence
  always_comb begin
    logic        fresh;
    logic        is_cont;
    logic [2:0]  total;
    logic [20:0] acc;
    logic [20:0] minv;
    logic        bad_value;

    fresh              = 1'b1;
    is_cont            = (byte_q & MASK_TOP2) == CONT_MARK;
    total              = {1'b0, held_count} + 3'd1;
    acc                = {partial_value[14:0], byte_q[5:0]};
    minv               = (total == 3'd2) ? MIN_TWO :
                         (total == 3'd3) ? MIN_THREE : MIN_FOUR;
    bad_value          = (acc < minv) || (acc > CP_MAX) ||
                         ((acc >= SURR_LO) && (acc <= SURR_HI));
    held_count_next    = held_count;
    needed_count_next  = needed_count;
    partial_value_next = partial_value;
    desc               = '0;
    desc.tail_cp       = CP_REPLACEMENT;
    desc.tail_bad      = 1'b1;
    desc.tail_cnt      = 3'd1;

    // continuation or break of a pending sequence
    if (held_count != 2'd0) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (needed_count <= 2'd1) begin
          if (bad_value) begin
            desc.rep_count = total;
          end else begin
            desc.tail_valid = 1'b1;
            desc.tail_cp    = acc;
            desc.tail_bad   = 1'b0;
            desc.tail_cnt   = total;
          end
          held_count_next    = 2'd0;
          needed_count_next  = 2'd0;
          partial_value_next = 21'd0;
        end else if (last_q) begin
          desc.rep_count     = total;
          held_count_next    = 2'd0;
          needed_count_next  = 2'd0;
          partial_value_next = 21'd0;
        end else begin
          held_count_next    = total[1:0];
          needed_count_next  = needed_count - 2'd1;
          partial_value_next = acc;
        end
      end else begin
        desc.rep_count     = {1'b0, held_count};
        held_count_next    = 2'd0;
        needed_count_next  = 2'd0;
        partial_value_next = 21'd0;
      end
    end

    // byte taken on its own
    if (fresh) begin
      if (!byte_q[7]) begin
        desc.tail_valid = 1'b1;
        desc.tail_cp    = {13'd0, byte_q};
        desc.tail_bad   = 1'b0;
      end else if ((byte_q & MASK_TOP3) == LEAD_TWO ||
                   (byte_q & MASK_TOP4) == LEAD_THREE ||
                   (byte_q & MASK_TOP5) == LEAD_FOUR) begin
        if (last_q) begin
          desc.tail_valid = 1'b1;
        end else begin
          held_count_next = 2'd1;
          if ((byte_q & MASK_TOP3) == LEAD_TWO) begin
            needed_count_next  = 2'd1;
            partial_value_next = {16'd0, byte_q[4:0]};
          end else if ((byte_q & MASK_TOP4) == LEAD_THREE) begin
            needed_count_next  = 2'd2;
            partial_value_next = {17'd0, byte_q[3:0]};
          end else begin
            needed_count_next  = 2'd3;
            partial_value_next = {18'd0, byte_q[2:0]};
          end
        end
      end else begin
        desc.tail_valid = 1'b1;
      end
    end
  end

endmodule

@@ hdl/u8d_emit.sv @@
// result register that plays out a descriptor's results, one per cycle while out_ready is high
module u8d_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  u8d_pkg::desc_t  desc,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [20:0]     code_point,
  output logic            malformed,
  output logic [2:0]      byte_count,
  output logic            last_of_run
);
  import u8d_pkg::*;

  logic [2:0]  rep_left;
  logic        tail_valid;
  logic [20:0] tail_cp;
  logic        tail_bad;
  logic [2:0]  tail_cnt;
  logic [2:0]  remaining;

  assign remaining = rep_left + {2'd0, tail_valid};
  assign out_valid = remaining != 3'd0;
  assign can_load  = !out_valid || (remaining == 3'd1 && out_ready);

  // current result
  assign code_point  = (rep_left != 3'd0) ? CP_REPLACEMENT : tail_cp;
  assign malformed   = (rep_left != 3'd0) ? 1'b1 : tail_bad;
  assign byte_count  = (rep_left != 3'd0) ? 3'd1 : tail_cnt;
  assign last_of_run = remaining == 3'd1;

  // descriptor register
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_left   <= 3'd0;
      tail_valid <= 1'b0;
    end else if (load) begin
      rep_left   <= desc.rep_count;
      tail_valid <= desc.tail_valid;
    end else if (out_valid && out_ready) begin
      if (rep_left != 3'd0) begin
        rep_left <= rep_left - 3'd1;
      end else begin
        tail_valid <= 1'b0;
      end
    end
    if (load) begin
      tail_cp  <= desc.tail_cp;
      tail_bad <= desc.tail_bad;
      tail_cnt <= desc.tail_cnt;
    end
  end

endmodule

@@ hdl/utf8_strict_decoder.sv @@
// strict utf-8 decoder top level: input register, decode, result register
// a byte waits in the input register and its results in the result register
// throughput: one byte per cycle while out_ready is high and each byte gives
// at most one result; a byte with more (up to four) holds the result register
// reset: synchronous, clears the pending sequence and both valid registers
module utf8_strict_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic        malformed,
  output logic [2:0]  byte_count,
  output logic        last_of_run
);
  import u8d_pkg::*;

  logic  can_load;
  logic  load;
  desc_t desc;

  // decode stage
  u8d_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .can_load   (can_load),
    .load       (load),
    .desc       (desc)
  );

  // result stage
  u8d_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .desc        (desc),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_point  (code_point),
    .malformed   (malformed),
    .byte_count  (byte_count),
    .last_of_run (last_of_run)
  );

endmodule
